>>> rtl/vector_angle_full_turn_macros.svh
`ifndef VECTOR_ANGLE_FULL_TURN_MACROS_SVH
`define VECTOR_ANGLE_FULL_TURN_MACROS_SVH

// same-cycle implication, disabled in reset
`define VAFT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define VAFT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/vaft_pkg.sv
`default_nettype none

package vaft_pkg;

  localparam int COMPONENT_WIDTH = 16;
  localparam int ANGLE_WIDTH     = 16;
  localparam int CORDIC_STAGES   = 16;
  localparam int GUARD_BITS      = 24;
  localparam int XW              = COMPONENT_WIDTH + GUARD_BITS + 3;

  // half an output step in 2^32-per-turn units, zero at full width
  localparam logic [31:0] ROUND_HALF = 32'((64'd1 << 32) >> (ANGLE_WIDTH + 1));

  localparam logic [ANGLE_WIDTH-1:0] ANGLE_QUARTER =
    ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 2);
  localparam logic [ANGLE_WIDTH-1:0] ANGLE_THREE_QUARTER =
    ANGLE_WIDTH'(3) << (ANGLE_WIDTH - 2);

  typedef enum logic [1:0] {
    QUAD_ZERO    = 2'd0,
    QUAD_QUARTER = 2'd1,
    QUAD_HALF    = 2'd2,
    QUAD_THREE   = 2'd3
  } quad_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic [31:0]          z;
    quad_t                quad;
    logic                 xzero;
  } cordic_t;

  // atan(2^-i), 2^32 units per turn
  function automatic logic [31:0] elem_angle(input int unsigned idx);
    logic [31:0] a;
    case (idx)
      0:  a = 32'd536870912;
      1:  a = 32'd316933406;
      2:  a = 32'd167458907;
      3:  a = 32'd85004756;
      4:  a = 32'd42667331;
      5:  a = 32'd21354465;
      6:  a = 32'd10679838;
      7:  a = 32'd5340245;
      8:  a = 32'd2670163;
      9:  a = 32'd1335087;
      10: a = 32'd667544;
      11: a = 32'd333772;
      12: a = 32'd166886;
      13: a = 32'd83443;
      14: a = 32'd41722;
      15: a = 32'd20861;
      16: a = 32'd10430;
      17: a = 32'd5215;
      18: a = 32'd2608;
      19: a = 32'd1304;
      20: a = 32'd652;
      21: a = 32'd326;
      22: a = 32'd163;
      23: a = 32'd81;
      24: a = 32'd41;
      25: a = 32'd20;
      26: a = 32'd10;
      27: a = 32'd5;
      28: a = 32'd3;
      29: a = 32'd1;
      30: a = 32'd1;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

>>> rtl/vaft_vec_if.sv
`default_nettype none

interface vaft_vec_if import vaft_pkg::*; ();
  logic                              valid;
  logic                              ready;
  logic signed [COMPONENT_WIDTH-1:0] vec_x;
  logic signed [COMPONENT_WIDTH-1:0] vec_y;

  modport source (output valid, output vec_x, output vec_y, input ready);
  modport sink (input valid, input vec_x, input vec_y, output ready);
endinterface

`default_nettype wire

>>> rtl/vaft_angle_if.sv
`default_nettype none

interface vaft_angle_if import vaft_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [ANGLE_WIDTH-1:0] angle;

  modport source (output valid, output angle, input ready);
  modport sink (input valid, input angle, output ready);
endinterface

`default_nettype wire

>>> rtl/vaft_fold.sv
`default_nettype none

module vaft_fold import vaft_pkg::*; (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              en,
  input  wire logic                              in_valid,
  input  wire logic signed [COMPONENT_WIDTH-1:0] vec_x,
  input  wire logic signed [COMPONENT_WIDTH-1:0] vec_y,
  output logic                                   out_valid,
  output cordic_t                                out_data
);

  logic signed [XW-1:0] xe;
  logic signed [XW-1:0] ye;
  logic                 y_pos;
  cordic_t              data_next;

  always_comb begin
    xe    = XW'(vec_x);
    ye    = XW'(vec_y);
    y_pos = !vec_y[COMPONENT_WIDTH-1] && (|vec_y);
    data_next.z = '0;
    if (!(|vec_x)) begin
      data_next.x     = '0;
      data_next.y     = '0;
      data_next.quad  = y_pos ? QUAD_QUARTER : QUAD_THREE;
      data_next.xzero = 1'b1;
    end else if (vec_x[COMPONENT_WIDTH-1]) begin
      data_next.x     = (-xe) <<< GUARD_BITS;
      data_next.y     = (-ye) <<< GUARD_BITS;
      data_next.quad  = QUAD_HALF;
      data_next.xzero = 1'b0;
    end else begin
      data_next.x     = xe <<< GUARD_BITS;
      data_next.y     = ye <<< GUARD_BITS;
      data_next.quad  = QUAD_ZERO;
      data_next.xzero = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= data_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/vaft_cordic.sv
`default_nettype none

module vaft_cordic import vaft_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    en,
  input  wire logic    in_valid,
  input  wire cordic_t in_data,
  output logic         out_valid,
  output cordic_t      out_data
);

  logic    stage_valid [0:CORDIC_STAGES];
  cordic_t stage_data  [0:CORDIC_STAGES];

  assign stage_valid[0] = in_valid;
  assign stage_data[0]  = in_data;

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
    logic signed [XW-1:0] xc;
    logic signed [XW-1:0] yc;
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    cordic_t              nxt;

    assign xc = stage_data[k].x;
    assign yc = stage_data[k].y;
    assign xs = xc >>> k;
    assign ys = yc >>> k;

    always_comb begin
      nxt = stage_data[k];
      if (!yc[XW-1]) begin
        nxt.x = xc + ys;
        nxt.y = yc - xs;
        nxt.z = stage_data[k].z + elem_angle(k);
      end else begin
        nxt.x = xc - ys;
        nxt.y = yc + xs;
        nxt.z = stage_data[k].z - elem_angle(k);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stage_valid[k+1] <= 1'b0;
      end else if (en) begin
        stage_valid[k+1] <= stage_valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stage_data[k+1] <= nxt;
      end
    end
  end

  assign out_valid = stage_valid[CORDIC_STAGES];
  assign out_data  = stage_data[CORDIC_STAGES];

endmodule

`default_nettype wire

>>> rtl/vaft_round.sv
`default_nettype none

module vaft_round import vaft_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire cordic_t          in_data,
  output logic                  out_valid,
  output logic [ANGLE_WIDTH-1:0] out_angle
);

  logic [31:0] turn;

  always_comb begin
    turn = {in_data.quad, 30'd0} + (in_data.xzero ? 32'd0 : in_data.z) + ROUND_HALF;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_angle <= turn[31 -: ANGLE_WIDTH];
    end
  end

endmodule

`default_nettype wire

>>> rtl/vector_angle_full_turn.sv
`default_nettype none
`include "vector_angle_full_turn_macros.svh"

// Direction of a signed (x, y) vector as an unsigned binary angle, 2^ANGLE_WIDTH
// steps per turn, zero along +x, growing counter-clockwise; x = 0 gives a quarter
// turn for positive y and three quarters otherwise (the zero vector included).
// Accurate to a few lsb. One transaction is accepted every cycle unless the
// output stalls. Pipeline: fold register, one register per unrolled CORDIC
// stage, rounding output register. A stalled output freezes the whole pipeline.

module vector_angle_full_turn import vaft_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  vaft_vec_if.sink      vec,
  vaft_angle_if.source  result
);

  logic    en;
  logic    fold_valid;
  cordic_t fold_data;
  logic    cd_valid;
  cordic_t cd_data;
  logic    axis_take;
  logic    axis_angle;

  assign en        = !result.valid || result.ready;
  assign vec.ready = en;

  assign axis_take  = en && cd_valid && cd_data.xzero;
  assign axis_angle = (result.angle == ANGLE_QUARTER) ||
                      (result.angle == ANGLE_THREE_QUARTER);

  vaft_fold u_fold (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vec.valid),
    .vec_x     (vec.vec_x),
    .vec_y     (vec.vec_y),
    .out_valid (fold_valid),
    .out_data  (fold_data)
  );

  vaft_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (fold_valid),
    .in_data   (fold_data),
    .out_valid (cd_valid),
    .out_data  (cd_data)
  );

  vaft_round u_round (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (cd_valid),
    .in_data   (cd_data),
    .out_valid (result.valid),
    .out_angle (result.angle)
  );

  `VAFT_ASSERT_NOW(a_stall_blocks_input, result.valid && !result.ready, !vec.ready, "input in stall")
  `VAFT_ASSERT_NEXT(a_xzero_angle, axis_take, result.valid && axis_angle, "zero x wrong angle")
  `VAFT_ASSERT_NEXT(a_bubble_passes, en && !cd_valid, !result.valid, "result without transaction")

endmodule

`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top import vaft_pkg::*; ();

  localparam int PIPE_LATENCY    = CORDIC_STAGES + 2;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int RANDOM_ITEMS    = 1580;
  localparam int PRESSURE_ITEMS  = 120;
  localparam int ATAN_ENTRIES    = 32;
  localparam int MAX_PRINTED     = 40;

  // angles in 2^32 units per turn
  localparam logic [63:0] QUARTER_TURN32       = 64'd1 << 30;
  localparam logic [63:0] HALF_TURN32          = 64'd1 << 31;
  localparam logic [63:0] THREE_QUARTER_TURN32 = 64'd3 << 30;

  localparam logic signed [COMPONENT_WIDTH-1:0] COMP_MAX = {1'b0, {(COMPONENT_WIDTH-1){1'b1}}};
  localparam logic signed [COMPONENT_WIDTH-1:0] COMP_MIN = {1'b1, {(COMPONENT_WIDTH-1){1'b0}}};

  typedef enum int {RX_STEADY, RX_COIN, RX_MOSTLY, RX_EVERY_THIRD} rx_pattern_t;

  typedef struct {
    logic signed [COMPONENT_WIDTH-1:0] x;
    logic signed [COMPONENT_WIDTH-1:0] y;
    logic [ANGLE_WIDTH-1:0]            angle;
  } angle_expect_t;

  logic clk;
  logic rst;

  vaft_vec_if   vec ();
  vaft_angle_if result ();

  vector_angle_full_turn dut (
    .clk    (clk),
    .rst    (rst),
    .vec    (vec),
    .result (result)
  );

  // atan(2^-i), 2^32 units per turn
  longint atan_turn32 [ATAN_ENTRIES] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5, 3, 1, 1, 0
  };

  angle_expect_t pending_angles[$];
  int            mismatch_count;
  int            hold_requests;
  int            burst_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [ANGLE_WIDTH-1:0] direction_of(
    input logic signed [COMPONENT_WIDTH-1:0] vx,
    input logic signed [COMPONENT_WIDTH-1:0] vy
  );
    longint      x;
    longint      y;
    longint      z;
    longint      xs;
    longint      ys;
    int          i;
    logic [63:0] turn32;
    logic [63:0] rounded;
    x = vx;
    y = vy;
    if (x == 0) begin
      turn32 = (y > 0) ? QUARTER_TURN32 : THREE_QUARTER_TURN32;
    end else begin
      // fold into the right half plane
      if (x < 0) begin
        x = -x;
        y = -y;
        turn32 = HALF_TURN32;
      end else begin
        turn32 = 64'd0;
      end
      x = x <<< GUARD_BITS;
      y = y <<< GUARD_BITS;
      z = 0;
      for (i = 0; i < CORDIC_STAGES && i < ATAN_ENTRIES; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + atan_turn32[i];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - atan_turn32[i];
        end
      end
      turn32 = turn32 + z;
    end
    // round half up, wrap modulo a full turn
    if (ANGLE_WIDTH < 32) begin
      rounded = (turn32 + (64'd1 << (31 - ANGLE_WIDTH))) >> (32 - ANGLE_WIDTH);
    end else begin
      rounded = turn32;
    end
    return rounded[ANGLE_WIDTH-1:0];
  endfunction

  function automatic logic signed [COMPONENT_WIDTH-1:0] random_component();
    logic signed [COMPONENT_WIDTH-1:0] c;
    case ($urandom_range(0, 7))
      0: c = COMPONENT_WIDTH'($signed($urandom_range(0, 8)) - 4);
      1: begin
        case ($urandom_range(0, 5))
          0: c = COMP_MIN;
          1: c = COMPONENT_WIDTH'(COMP_MIN + 1);
          2: c = COMP_MAX;
          3: c = '0;
          4: c = 1;
          default: c = -1;
        endcase
      end
      2: c = COMPONENT_WIDTH'($signed($urandom_range(0, 512)) - 256);
      default: c = COMPONENT_WIDTH'($urandom);
    endcase
    return c;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTED) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  task automatic send_vector(
    input logic signed [COMPONENT_WIDTH-1:0] vx,
    input logic signed [COMPONENT_WIDTH-1:0] vy
  );
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        vec.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    vec.valid <= 1'b1;
    vec.vec_x <= vx;
    vec.vec_y <= vy;
    @(posedge clk);
    while (vec.ready !== 1'b1) @(posedge clk);
  endtask

  task automatic send_random_pair();
    logic signed [COMPONENT_WIDTH-1:0] vx;
    logic signed [COMPONENT_WIDTH-1:0] vy;
    vx = random_component();
    vy = random_component();
    case ($urandom_range(0, 9))
      0: vx = '0;
      1: vy = '0;
      2: vy = vx;
      3: vy = -vx;
      4: begin
        vx = COMPONENT_WIDTH'($urandom);
        vy = COMPONENT_WIDTH'($urandom);
      end
      default: ;
    endcase
    send_vector(vx, vy);
  endtask

  task automatic test_axes_and_zero();
    send_vector(0, 0);
    send_vector(0, 1);
    send_vector(0, -1);
    send_vector(0, COMP_MAX);
    send_vector(0, COMP_MIN);
    send_vector(1, 0);
    send_vector(-1, 0);
    send_vector(COMP_MAX, 0);
    send_vector(COMP_MIN, 0);
  endtask

  task automatic test_extreme_vectors();
    send_vector(COMP_MAX, COMP_MAX);
    send_vector(COMP_MIN, COMP_MIN);
    send_vector(COMP_MAX, COMP_MIN);
    send_vector(COMP_MIN, COMP_MAX);
    send_vector(1, -1);
    send_vector(-1, -1);
    // tiny negative angle rounds up to a full turn
    send_vector(COMP_MAX, -1);
    send_vector(COMP_MIN, 1);
    send_vector(1, COMP_MIN);
    send_vector(-1, COMP_MAX);
  endtask

  task automatic test_output_backpressure();
    int n;
    hold_requests <= hold_requests + 1;
    for (n = 0; n < PRESSURE_ITEMS; n++) begin
      send_random_pair();
    end
  endtask

  task automatic test_random_vectors();
    int n;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      send_random_pair();
    end
  endtask

  // result receiver with its own stall pattern and long hold-off
  initial begin : receiver
    int          seg_left;
    int          holds_seen;
    int          stall_left;
    rx_pattern_t pattern;
    seg_left   = 0;
    holds_seen = 0;
    stall_left = 0;
    pattern    = RX_STEADY;
    result.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_seen) begin
        holds_seen = hold_requests;
        stall_left = HOLD_OFF_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        result.ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(8, 120);
          pattern  = rx_pattern_t'($urandom_range(0, 3));
        end
        seg_left--;
        case (pattern)
          RX_STEADY:  result.ready <= 1'b1;
          RX_COIN:    result.ready <= ($urandom_range(0, 1) == 1);
          RX_MOSTLY:  result.ready <= ($urandom_range(0, 4) != 0);
          default:    result.ready <= (seg_left % 3 != 0);
        endcase
      end
    end
  end

  // expectation on input transaction, compare on output transaction
  always @(posedge clk) begin : scoreboard
    angle_expect_t e;
    if (!rst) begin
      if (vec.valid === 1'b1 && vec.ready === 1'b1) begin
        e.x     = vec.vec_x;
        e.y     = vec.vec_y;
        e.angle = direction_of(vec.vec_x, vec.vec_y);
        pending_angles.push_back(e);
      end
      if (result.valid === 1'b1 && result.ready === 1'b1) begin
        if (pending_angles.size() == 0) begin
          report_mismatch($sformatf("angle %0d with no transaction pending", result.angle));
        end else begin
          e = pending_angles.pop_front();
          if (result.angle !== e.angle) begin
            report_mismatch($sformatf("vec (%0d,%0d) angle %0d expected %0d",
                                      e.x, e.y, result.angle, e.angle));
          end
        end
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((vec.valid === 1'b1 && vec.ready === 1'b1) ||
          (result.valid === 1'b1 && result.ready === 1'b1)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : main
    mismatch_count = 0;
    hold_requests  = 0;
    burst_left     = 0;
    rst       <= 1'b1;
    vec.valid <= 1'b0;
    vec.vec_x <= '0;
    vec.vec_y <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_axes_and_zero();
    test_extreme_vectors();
    test_output_backpressure();
    test_random_vectors();
    vec.valid <= 1'b0;
    while (pending_angles.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 4) @(posedge clk);
    if (mismatch_count == 0 && pending_angles.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
